/* rtl/core/linear_inverse_quantizer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear inverse quantizer.
// Both macros sample on the rising clock edge and are disabled while rst_n
// is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INVERSE_QUANTIZER_MACROS_SVH
`define LINEAR_INVERSE_QUANTIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/liq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liq_pkg
// Types, codes and helpers shared by the linear inverse quantizer modules.
// ----------------------------------------------------------------------------
package liq_pkg;

  localparam int CODE_W = 31;             // width of a quantized code
  localparam int QW     = 32;             // quotient bits, one per divider cell
  localparam int ACC_W  = CODE_W + QW;    // product / divider accumulator width

  // Opcodes.
  localparam logic [1:0] OP_LINEAR = 2'd0;
  localparam logic [1:0] OP_INT    = 2'd1;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_NB_BITS  = 3'd0;
  localparam logic [2:0] REG_MIN_X    = 3'd1;
  localparam logic [2:0] REG_MIN_Y    = 3'd2;
  localparam logic [2:0] REG_MIN_Z    = 3'd3;
  localparam logic [2:0] REG_MAX_X    = 3'd4;
  localparam logic [2:0] REG_MAX_Y    = 3'd5;
  localparam logic [2:0] REG_MAX_Z    = 3'd6;
  localparam logic [2:0] REG_INT_BASE = 3'd7;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        component;
    logic [CODE_W-1:0] code;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_word_t;

  // Register file contents; index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [4:0]       nb_bits;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
    logic [31:0]      int_base;
  } liq_cfg_t;

  // Side information that travels next to the divider accumulator.
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic        pass;    // result is base as it stands, quotient unused
    logic        neg;     // subtract the quotient from base
    logic [31:0] base;
  } liq_side_t;

  // Largest legal code for a given number of bits: 2^nb - 1.
  function automatic logic [CODE_W-1:0] code_top(input logic [4:0] nb);
    logic [31:0] t;
    t = (32'd1 << nb) - 32'd1;
    return t[CODE_W-1:0];
  endfunction

endpackage

/* rtl/core/liq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liq_front
// Decode stage and multiply stage ahead of the divider chain.
// ----------------------------------------------------------------------------
module liq_front import liq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  in_word_t          in_word,
  input  liq_cfg_t          cfg,
  input  logic [CODE_W-1:0] top,
  output liq_side_t         side_o,
  output logic [ACC_W-1:0]  acc_o
);

  logic [1:0]        sel;
  logic [31:0]       lo;
  logic [31:0]       hi;
  logic [32:0]       diff;
  logic [32:0]       mag_w;
  liq_side_t         side1_nxt;
  liq_side_t         side1_r;
  logic [31:0]       mag1_r;
  logic [CODE_W-1:0] code1_r;
  liq_side_t         side2_r;
  logic [ACC_W-1:0]  acc2_r;

  always_comb begin
    // Component three falls back to the z bounds.
    case (in_word.component)
      2'd0:    sel = 2'd0;
      2'd1:    sel = 2'd1;
      default: sel = 2'd2;
    endcase
    lo    = cfg.lo[sel];
    hi    = cfg.hi[sel];
    diff  = {hi[31], hi} - {lo[31], lo};
    mag_w = diff[32] ? (33'd0 - diff) : diff;

    side1_nxt        = '0;
    side1_nxt.valid  = in_valid;
    side1_nxt.status = ST_OK;
    side1_nxt.pass   = 1'b1;
    if (in_word.opcode != OP_LINEAR && in_word.opcode != OP_INT) begin
      side1_nxt.status = ST_BAD_OP;
    end else if (in_word.code > top) begin
      side1_nxt.status = ST_RANGE;
    end else if (in_word.opcode == OP_LINEAR) begin
      // A zero code gives min exactly, also when the divisor is zero.
      side1_nxt.base = lo;
      side1_nxt.neg  = diff[32];
      side1_nxt.pass = (in_word.code == '0);
    end else begin
      side1_nxt.base = {1'b0, in_word.code} + cfg.int_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
    end else if (en) begin
      side1_r <= side1_nxt;
      side2_r <= side1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag_w[31:0];
      code1_r <= in_word.code;
      acc2_r  <= {{CODE_W{1'b0}}, mag1_r} * {{QW{1'b0}}, code1_r};
    end
  end

  assign side_o = side2_r;
  assign acc_o  = acc2_r;

endmodule

/* rtl/core/liq_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liq_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module liq_div_cell import liq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CODE_W-1:0] top,
  input  liq_side_t         side_i,
  input  logic [ACC_W-1:0]  acc_i,
  output liq_side_t         side_o,
  output logic [ACC_W-1:0]  acc_o
);

  logic [QW-1:0]     trial;
  logic [QW-1:0]     sub;
  logic              ge;
  logic [CODE_W-1:0] rem;
  liq_side_t         side_r;
  logic [ACC_W-1:0]  acc_r;

  // The accumulator holds the partial remainder on top, the dividend bits
  // still to come below it, and the quotient bits shifting in at the bottom.
  always_comb begin
    trial = acc_i[ACC_W-1:QW-1];
    sub   = trial - {1'b0, top};
    ge    = (trial >= {1'b0, top});
    rem   = ge ? sub[CODE_W-1:0] : trial[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= {rem, acc_i[QW-2:0], ge};
    end
  end

  assign side_o = side_r;
  assign acc_o  = acc_r;

endmodule

/* rtl/core/linear_inverse_quantizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_inverse_quantizer
// Maps quantized codes back onto a linear 16.16 range or an integer offset.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   in_      input      in_valid / in_stall    in_word_t  (opcode, component, code)
//   out_     output     out_valid / out_stall  out_word_t (value, status)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The block takes one word per cycle unless the input is stalled. It has one
// decode stage, one 32 x 31 multiply stage, a chain of 32 divider cells that
// each resolve one quotient bit, and the output register.
// Reset is synchronous and active low; it restores the register defaults and
// empties the pipeline. The configuration port is always ready.
// A stalled result waits in the output register while one more word lands in
// a skid register; only a full skid register stalls the input and freezes the
// pipeline.
// ----------------------------------------------------------------------------

`include "linear_inverse_quantizer_macros.svh"

module linear_inverse_quantizer import liq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  liq_cfg_t          cfg_r;
  liq_cfg_t          cfg_nxt;
  logic [CODE_W-1:0] top;
  logic              en;

  liq_side_t         side_c [QW+1];
  logic [ACC_W-1:0]  acc_c  [QW+1];

  liq_side_t         side_end;
  logic [QW-1:0]     quo;
  out_word_t         res;
  logic              push;
  logic              pop;

  out_word_t         out_word_r;
  logic              out_valid_r;
  out_word_t         skid_word_r;
  logic              skid_valid_r;

  // Register file. The user must send writes only while no word is in flight;
  // the block does not enforce it, and the pipeline reads the registers directly.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_NB_BITS:  cfg_nxt.nb_bits  = cfg_data[4:0];
        REG_MIN_X:    cfg_nxt.lo[0]    = cfg_data;
        REG_MIN_Y:    cfg_nxt.lo[1]    = cfg_data;
        REG_MIN_Z:    cfg_nxt.lo[2]    = cfg_data;
        REG_MAX_X:    cfg_nxt.hi[0]    = cfg_data;
        REG_MAX_Y:    cfg_nxt.hi[1]    = cfg_data;
        REG_MAX_Z:    cfg_nxt.hi[2]    = cfg_data;
        REG_INT_BASE: cfg_nxt.int_base = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nb_bits  <= 5'd8;
      cfg_r.lo       <= '0;
      cfg_r.hi       <= {3{32'd65536}};
      cfg_r.int_base <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The divisor 2^nb_bits - 1 is shared by the range check and every cell.
  assign top = code_top(cfg_r.nb_bits);

  // The whole pipeline advances unless the skid register is occupied.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  liq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .cfg      (cfg_r),
    .top      (top),
    .side_o   (side_c[0]),
    .acc_o    (acc_c[0])
  );

  // Because the code never exceeds the divisor, the quotient fits in 32 bits
  // and the upper 31 product bits start out below the divisor.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    liq_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .top    (top),
      .side_i (side_c[i]),
      .acc_i  (acc_c[i]),
      .side_o (side_c[i+1]),
      .acc_o  (acc_c[i+1])
    );
  end

  // Final correction: add or subtract the quotient from the lower bound, or
  // pass the precomputed value through for integer mode, zero codes and
  // errors. Sums wrap modulo 2^32.
  always_comb begin
    side_end   = side_c[QW];
    quo        = acc_c[QW][QW-1:0];
    res.status = side_end.status;
    if (side_end.pass) begin
      res.value = side_end.base;
    end else if (side_end.neg) begin
      res.value = side_end.base - quo;
    end else begin
      res.value = side_end.base + quo;
    end
  end

  assign push = en && side_end.valid;
  assign pop  = out_valid_r && !out_stall;

  // Output register with a one-word skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_word_r   <= skid_word_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (push) begin
          out_word_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (push) begin
        skid_word_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The skid register only ever holds a word behind a held output word.
  `LIQ_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid word without output word")

  // A word leaving the pipeline into a stalled output lands in the skid register.
  `LIQ_ASSERT_NEXT(a_skid_fill, clk, rst_n, out_valid_r && out_stall && push, skid_valid_r, "stalled word was dropped")

  // When the output is taken, the skid word moves up and the skid register empties.
  `LIQ_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r && out_word_r == $past(skid_word_r), "skid word not forwarded")

  // Any error status comes with a zero value.
  `LIQ_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid_r && out_word_r.status != ST_OK, out_word_r.value == 32'sd0, "error word with nonzero value")

endmodule

/* verif/liq_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the linear inverse quantizer
// Follows the register writes, computes the result word for every word the
// block takes, and compares each result word with the oldest one in flight.
// ----------------------------------------------------------------------------
module liq_result_checker import liq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          linear_seen,
  output int          offset_seen,
  output int          rejected_seen
);

  // Shadow registers. Entry 3 of each bound table mirrors z, so component 3
  // picks the z bounds without a special case.
  logic [4:0]  nb_bits;
  logic [31:0] lo [4];
  logic [31:0] hi [4];
  logic [31:0] int_base;

  out_word_t expected_words [$];
  out_word_t want;
  int        fail_count   = 0;
  int        result_count = 0;
  int        linear_count = 0;
  int        offset_count = 0;
  int        reject_count = 0;

  function automatic out_word_t dequantize(input in_word_t w);
    out_word_t   r;
    logic [63:0] top;
    logic [63:0] span;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [31:0] lo_v;
    logic [31:0] hi_v;
    r.value  = '0;
    r.status = ST_OK;
    top  = (64'd1 << nb_bits) - 64'd1;
    lo_v = lo[w.component];
    hi_v = hi[w.component];
    if (w.opcode != OP_LINEAR && w.opcode != OP_INT) begin
      r.status = ST_BAD_OP;
    end else if (64'(w.code) > top) begin
      r.status = ST_RANGE;
    end else if (w.opcode == OP_INT) begin
      r.value = {1'b0, w.code} + int_base;
    end else if (w.code == '0) begin
      r.value = lo_v;
    end else if (64'(w.code) == top) begin
      r.value = hi_v;
    end else begin
      // The product of a 32-bit magnitude and a 31-bit code fits 63 bits.
      span = {{32{hi_v[31]}}, hi_v} - {{32{lo_v[31]}}, lo_v};
      mag  = span[63] ? -span : span;
      quot = (mag * 64'(w.code)) / top;
      r.value = span[63] ? lo_v - quot[31:0] : lo_v + quot[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      nb_bits  = 5'd8;
      int_base = '0;
      for (int i = 0; i < 4; i++) begin
        lo[i] = '0;
        hi[i] = 32'h0001_0000;
      end
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_words.size() == 0) begin
          $error("result word with nothing in flight: value %0d status %0d",
                 out_word.value, out_word.status);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d", want.value, out_word.value);
            fail_count++;
          end
          if (out_word.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_word.status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = dequantize(in_word);
        expected_words.push_back(want);
        if (want.status != ST_OK) reject_count++;
        else if (in_word.opcode == OP_INT) offset_count++;
        else linear_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NB_BITS:  nb_bits = cfg_data[4:0];
          REG_MIN_X:    lo[0] = cfg_data;
          REG_MIN_Y:    lo[1] = cfg_data;
          REG_MIN_Z: begin
            lo[2] = cfg_data;
            lo[3] = cfg_data;
          end
          REG_MAX_X:    hi[0] = cfg_data;
          REG_MAX_Y:    hi[1] = cfg_data;
          REG_MAX_Z: begin
            hi[2] = cfg_data;
            hi[3] = cfg_data;
          end
          REG_INT_BASE: int_base = cfg_data;
          default: ;
        endcase
      end
    end
    errors        <= fail_count;
    pending       <= expected_words.size();
    checked       <= result_count;
    linear_seen   <= linear_count;
    offset_seen   <= offset_count;
    rejected_seen <= reject_count;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the linear inverse quantizer
// Drives directed and random code words through the block under a series of
// register settings, with random gaps on the input and random stalls on the
// output, and lets the result checker compare every result word.
// ----------------------------------------------------------------------------
module testbench;
  import liq_pkg::*;

  // The two opcodes the block must reject.
  localparam logic [1:0] OP_RESERVED_2 = 2'd2;
  localparam logic [1:0] OP_RESERVED_3 = 2'd3;

  // Component selects; the fourth one aliases z.
  localparam logic [1:0] COMP_X     = 2'd0;
  localparam logic [1:0] COMP_Y     = 2'd1;
  localparam logic [1:0] COMP_Z     = 2'd2;
  localparam logic [1:0] COMP_ALIAS = 2'd3;

  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

  localparam int PIPE_LATENCY    = 35;   // pipeline depth of the block
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 83;
  localparam int IDLE_LIMIT      = 3000; // cycles without any handshake

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int errors;
  int pending;
  int checked;
  int linear_seen;
  int offset_seen;
  int rejected_seen;

  // Per-phase switches for the input gaps and the output stalls. Some phases
  // turn both off so the block also sees stretches of back-to-back words.
  bit idle_on   = 1'b1;
  bit stall_on  = 1'b1;
  int settings  = 1;
  int quiet     = 0;

  always #5 clk = ~clk;

  linear_inverse_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  liq_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .linear_seen   (linear_seen),
    .offset_seen   (offset_seen),
    .rejected_seen (rejected_seen)
  );

  // Gap lengths: mostly none or short, now and then a long pause so the
  // pipeline can drain completely or the skid register fills up.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bounds lean on the signed extremes and zero; a random pair of bounds is
  // inverted about half of the time.
  function automatic logic [31:0] pick_bound();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return S32_MIN;
    if (r < 24) return S32_MAX;
    if (r < 32) return '0;
    return $urandom();
  endfunction

  // Offers one word, after an optional gap, and returns at the edge where
  // the block takes it. The word stays put for as long as in_stall is high.
  task automatic push(input logic [1:0] op, input logic [1:0] comp,
                      input logic [CODE_W-1:0] code);
    int gap;
    gap = idle_on ? gap_cycles() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {op, comp, code};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Registers may only change while nothing is in flight. Every word gives
  // exactly one result word, so an empty checker queue plus the pipeline
  // depth means the block is idle. The checker's count is registered, so it
  // is trusted only from the next edge on.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // Writes all eight registers back to back; valid drops only after the last.
  task automatic write_config(input logic [31:0] regs [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= regs[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Output back-pressure: alternating runs of ready and stalled cycles.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      repeat (1 + gap_cycles()) @(posedge clk);
      if (stall_on) begin
        out_stall <= 1'b1;
        repeat (1 + gap_cycles()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d words in flight.",
                 quiet, pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0]       regs [8];
    logic [31:0]       top;
    logic [31:0]       below_top;
    logic [1:0]        op;
    logic [1:0]        comp;
    logic [CODE_W-1:0] code;
    int                r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: eight-bit codes over [0, 1.0] on every component.
    // Ends of the range, the midpoint, the fourth component select, both
    // rejected opcodes (one with a code that is also out of range, where the
    // opcode error must win) and codes just past and far past the range.
    push(OP_LINEAR, COMP_X, 31'd0);
    push(OP_LINEAR, COMP_Y, 31'd255);
    push(OP_LINEAR, COMP_Z, 31'd128);
    push(OP_LINEAR, COMP_ALIAS, 31'd1);
    push(OP_INT, COMP_X, 31'd0);
    push(OP_INT, COMP_Y, 31'd255);
    push(OP_RESERVED_2, COMP_X, 31'd5);
    push(OP_RESERVED_3, COMP_Z, 31'd300);
    push(OP_LINEAR, COMP_X, 31'd256);
    push(OP_INT, COMP_Z, 31'h7fff_ffff);

    // Zero-bit codes: only code 0 is legal and it yields min. The y bounds
    // are the widest possible inverted pair.
    settle();
    regs[REG_NB_BITS]  = 32'd0;
    regs[REG_MIN_X]    = S32_MIN;
    regs[REG_MAX_X]    = S32_MAX;
    regs[REG_MIN_Y]    = S32_MAX;
    regs[REG_MAX_Y]    = S32_MIN;
    regs[REG_MIN_Z]    = 32'hffff_fffb;
    regs[REG_MAX_Z]    = 32'd7;
    regs[REG_INT_BASE] = S32_MAX;
    write_config(regs);
    push(OP_LINEAR, COMP_X, 31'd0);
    push(OP_LINEAR, COMP_Y, 31'd1);
    push(OP_INT, COMP_X, 31'd0);
    push(OP_LINEAR, COMP_Z, 31'd0);

    // Full 31-bit codes: all-ones must give max exactly, the inverted span
    // truncates toward zero, and the integer offset wraps around.
    settle();
    regs[REG_NB_BITS] = 32'd31;
    write_config(regs);
    push(OP_LINEAR, COMP_X, 31'h7fff_ffff);
    push(OP_LINEAR, COMP_Y, 31'h4000_0000);
    push(OP_LINEAR, COMP_ALIAS, 31'h3fff_ffff);
    push(OP_INT, COMP_X, 31'h7fff_ffff);

    // Random phases. The first two pin the extremes of every register; the
    // rest draw code widths and bounds at random, some with narrow spans.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          regs[REG_NB_BITS] = 32'd31;
          for (int k = 0; k < 3; k++) begin
            regs[REG_MIN_X + k] = S32_MIN;
            regs[REG_MAX_X + k] = S32_MAX;
          end
          regs[REG_INT_BASE] = S32_MAX;
        end
        1: begin
          regs[REG_NB_BITS] = 32'd0;
          for (int k = 0; k < 3; k++) begin
            regs[REG_MIN_X + k] = S32_MAX;
            regs[REG_MAX_X + k] = S32_MIN;
          end
          regs[REG_INT_BASE] = S32_MIN;
        end
        default: begin
          if (p == 2) regs[REG_NB_BITS] = 32'd1;
          else if ($urandom_range(0, 3) == 0) regs[REG_NB_BITS] = $urandom_range(1, 4);
          else regs[REG_NB_BITS] = $urandom_range(0, 31);
          for (int k = 0; k < 3; k++) begin
            regs[REG_MIN_X + k] = pick_bound();
            if ($urandom_range(0, 3) == 0) begin
              regs[REG_MAX_X + k] = regs[REG_MIN_X + k] + $urandom_range(0, 32'h0003_0000);
            end else begin
              regs[REG_MAX_X + k] = pick_bound();
            end
          end
          regs[REG_INT_BASE] = pick_bound();
        end
      endcase
      idle_on  = (p % 4 != 3);
      stall_on = idle_on;
      write_config(regs);

      top       = (32'd1 << regs[REG_NB_BITS][4:0]) - 32'd1;
      below_top = top - 32'd1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) op = $urandom_range(0, 1) ? OP_RESERVED_2 : OP_RESERVED_3;
        else if (r < 30) op = OP_INT;
        else op = OP_LINEAR;
        comp = 2'($urandom_range(0, 3));
        // Codes favor the ends of the legal range; a share lands past it,
        // and fully random codes exercise every code bit.
        r = $urandom_range(0, 99);
        if (r < 10) code = '0;
        else if (r < 20) code = top[CODE_W-1:0];
        else if (r < 26) code = below_top[CODE_W-1:0];
        else if (r < 30) code = 31'd1;
        else if (r < 85) code = 31'($urandom_range(0, top));
        else if (r < 93 && top != S32_MAX) code = 31'($urandom_range(top + 1, S32_MAX));
        else code = 31'($urandom());
        push(op, comp, code);
      end
    end

    idle_on  = 1'b1;
    stall_on = 1'b1;
    settle();

    $display("Checked %0d result words under %0d register settings.", checked, settings);
    $display("Linear %0d, integer offset %0d, rejected by opcode or range %0d.",
             linear_seen, offset_seen, rejected_seen);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/liq_pkg.sv
rtl/core/liq_front.sv
rtl/core/liq_div_cell.sv
rtl/core/linear_inverse_quantizer.sv
verif/liq_result_checker.sv
verif/testbench.sv
